[rtl/core/mte_pkg.sv]
`timescale 1ns / 1ps
// mte_pkg: shared constants, command codes and control types of the multiset table engine.
// No dependencies; used by mte_cell, mte_head and multiset_table_engine_core.
package mte_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [1:0] CMD_INSERT       = 2'd0;
    localparam logic [1:0] CMD_REMOVE_LAST  = 2'd1;
    localparam logic [1:0] CMD_REMOVE_FIRST = 2'd2;
    localparam logic [1:0] CMD_QUERY        = 2'd3;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // broadcast to every cell
    typedef struct packed {
        logic             rotate;
        logic             compact;
        logic             load;
        logic [IDX_W-1:0] del_idx;
        logic [IDX_W-1:0] ins_idx;
        t_word            value;
    } t_cell_ctl;

    // head scan unit control
    typedef struct packed {
        logic             start;
        logic             step_ok;
        logic             first_only;
        logic [IDX_W-1:0] step;
        t_word            key;
    } t_scan_ctl;

    // head scan unit results
    typedef struct packed {
        logic [1:0]       hits;
        logic [IDX_W-1:0] hit_idx;
        t_word            mn;
        t_word            mx;
    } t_scan_res;

endpackage

[rtl/core/mte_cell.sv]
`timescale 1ns / 1ps
// mte_cell: one table slot of the ring; rotates, closes a gap or loads a new value.
// Depends on mte_pkg.
module mte_cell (
    input  logic                     i_clk,
    input  mte_pkg::t_cell_ctl       i_ctl,
    input  logic [mte_pkg::IDX_W-1:0] i_index,
    input  mte_pkg::t_word           i_ring,
    input  mte_pkg::t_word           i_up,
    output mte_pkg::t_word           o_value
);

    mte_pkg::t_word r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_value <= i_ring;
        end else if (i_ctl.compact && (i_index >= i_ctl.del_idx)) begin
            r_value <= i_up;
        end else if (i_ctl.load && (i_index == i_ctl.ins_idx)) begin
            r_value <= i_ctl.value;
        end
    end

    assign o_value = r_value;

endmodule

[rtl/core/mte_head.sv]
`timescale 1ns / 1ps
// mte_head: scan unit at the ring head; matches the key, tracks match index, min and max.
// Depends on mte_pkg.
module mte_head (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mte_pkg::t_scan_ctl i_ctl,
    input  mte_pkg::t_word     i_entry,
    output mte_pkg::t_scan_res o_res
);

    logic [1:0]                r_hits;
    logic [mte_pkg::IDX_W-1:0] r_hit_idx;
    mte_pkg::t_word            r_mn;
    mte_pkg::t_word            r_mx;
    logic                      w_eq;

    assign w_eq = (i_entry == i_ctl.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= 2'd0;
        end else if (i_ctl.start) begin
            r_hits <= 2'd0;
        end else if (i_ctl.step_ok && w_eq && (r_hits != 2'd2)) begin
            r_hits <= r_hits + 2'd1;
        end
    end

    // matching entries stay out of min/max; the core adds the key back
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hit_idx <= '0;
            r_mn      <= mte_pkg::WORD_MAX;
            r_mx      <= mte_pkg::WORD_MIN;
        end else if (i_ctl.step_ok) begin
            if (w_eq) begin
                if (!i_ctl.first_only || (r_hits == 2'd0)) begin
                    r_hit_idx <= i_ctl.step;
                end
            end else begin
                if (i_entry < r_mn) begin
                    r_mn <= i_entry;
                end
                if (i_entry > r_mx) begin
                    r_mx <= i_entry;
                end
            end
        end
    end

    assign o_res.hits    = r_hits;
    assign o_res.hit_idx = r_hit_idx;
    assign o_res.mn      = r_mn;
    assign o_res.mx      = r_mx;

endmodule

[rtl/core/multiset_table_engine_core.sv]
`timescale 1ns / 1ps
// multiset_table_engine_core: top level; ring of table cells, head scan unit, command control.
// Depends on mte_pkg, mte_cell and mte_head.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  command | i_valid / o_stall   | i_cmd, i_value
//  result  | o_valid / i_stall   | o_found, o_position, o_overflow, o_entry_count,
//          |                     | o_min_value, o_max_value
//
// Each command is accepted, makes one full turn of the cell ring past the head scan unit,
// then finalizes, closing the gap or appending.
// Reset empties the table at once; cell contents need no clearing.
// A stalled result is held in the output register; the next command is taken meanwhile
// and waits in finalize only if the previous result is still not taken.
module multiset_table_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_found,
    output logic [mte_pkg::POS_W-1:0]   o_position,
    output logic                        o_overflow,
    output logic [mte_pkg::COUNT_W-1:0] o_entry_count,
    output logic signed [31:0]          o_min_value,
    output logic signed [31:0]          o_max_value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [mte_pkg::IDX_W-1:0] r_step;
    logic [mte_pkg::CNT_W-1:0] r_occ;
    logic [mte_pkg::CNT_W-1:0] n_occ;
    logic [1:0]                r_cmd;
    mte_pkg::t_word            r_key;

    logic                        r_o_valid;
    logic                        r_o_found;
    logic [mte_pkg::POS_W-1:0]   r_o_position;
    logic                        r_o_overflow;
    logic [mte_pkg::COUNT_W-1:0] r_o_count;
    mte_pkg::t_word              r_o_min;
    mte_pkg::t_word              r_o_max;

    mte_pkg::t_cell_ctl w_cell_ctl;
    mte_pkg::t_scan_ctl w_scan_ctl;
    mte_pkg::t_scan_res w_res;
    mte_pkg::t_word     w_cell [mte_pkg::CAPACITY];

    logic w_accept;
    logic w_out_take;
    logic w_fin_go;
    logic w_scan_last;
    logic w_is_ins;
    logic w_is_rem;
    logic w_full;
    logic w_hit;
    logic w_ins_ok;
    logic w_rem_ok;
    logic w_incl_key;
    logic w_found;
    logic [mte_pkg::POS_W-1:0] w_pos;
    mte_pkg::t_word w_fin_mn;
    mte_pkg::t_word w_fin_mx;

    assign o_stall     = (r_state != ST_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_out_take  = r_o_valid && !i_stall;
    assign w_fin_go    = (r_state == ST_FIN) && (!r_o_valid || !i_stall);
    assign w_scan_last = (r_step == mte_pkg::IDX_W'(mte_pkg::CAPACITY - 1));

    // finalize decode
    assign w_is_ins   = (r_cmd == mte_pkg::CMD_INSERT);
    assign w_is_rem   = (r_cmd == mte_pkg::CMD_REMOVE_LAST) ||
                        (r_cmd == mte_pkg::CMD_REMOVE_FIRST);
    assign w_full     = (r_occ == mte_pkg::CNT_W'(mte_pkg::CAPACITY));
    assign w_hit      = (w_res.hits != 2'd0);
    assign w_ins_ok   = w_is_ins && !w_full;
    assign w_rem_ok   = w_is_rem && w_hit;
    // key still present in the table after the command
    assign w_incl_key = w_is_ins ? (w_ins_ok || w_hit) :
                        w_is_rem ? (w_res.hits == 2'd2) : w_hit;
    assign w_found    = w_ins_ok || (!w_is_ins && w_hit);
    assign w_pos      = w_ins_ok ? mte_pkg::POS_W'(r_occ[mte_pkg::IDX_W-1:0]) :
                        w_rem_ok ? mte_pkg::POS_W'(w_res.hit_idx) : '0;
    assign w_fin_mn   = (w_incl_key && (r_key < w_res.mn)) ? r_key : w_res.mn;
    assign w_fin_mx   = (w_incl_key && (r_key > w_res.mx)) ? r_key : w_res.mx;

    always_comb begin
        n_occ = r_occ;
        if (w_ins_ok) begin
            n_occ = r_occ + mte_pkg::CNT_W'(1);
        end else if (w_rem_ok) begin
            n_occ = r_occ - mte_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_step <= r_step + mte_pkg::IDX_W'(1);
            end else begin
                r_step <= '0;
            end
            if (w_fin_go) begin
                r_occ     <= n_occ;
                r_o_valid <= 1'b1;
            end else if (w_out_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= i_value;
        end
        if (w_fin_go) begin
            r_o_found    <= w_found;
            r_o_position <= w_pos;
            r_o_overflow <= w_is_ins && w_full;
            r_o_count    <= mte_pkg::COUNT_W'(n_occ);
            r_o_min      <= w_fin_mn;
            r_o_max      <= w_fin_mx;
        end
    end

    assign w_cell_ctl.rotate  = (r_state == ST_SCAN);
    assign w_cell_ctl.compact = w_fin_go && w_rem_ok;
    assign w_cell_ctl.load    = w_fin_go && w_ins_ok;
    assign w_cell_ctl.del_idx = w_res.hit_idx;
    assign w_cell_ctl.ins_idx = r_occ[mte_pkg::IDX_W-1:0];
    assign w_cell_ctl.value   = r_key;

    assign w_scan_ctl.start      = w_accept;
    assign w_scan_ctl.step_ok    = (r_state == ST_SCAN) &&
                                   (mte_pkg::CNT_W'(r_step) < r_occ);
    assign w_scan_ctl.first_only = (r_cmd == mte_pkg::CMD_REMOVE_FIRST);
    assign w_scan_ctl.step       = r_step;
    assign w_scan_ctl.key        = r_key;

    genvar k;
    generate
        for (k = 0; k < mte_pkg::CAPACITY; k++) begin : g_cell
            if (k == mte_pkg::CAPACITY - 1) begin : g_tail
                mte_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (w_cell_ctl),
                    .i_index (mte_pkg::IDX_W'(k)),
                    .i_ring  (w_cell[0]),
                    .i_up    (w_cell[k]),
                    .o_value (w_cell[k])
                );
            end else begin : g_body
                mte_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (w_cell_ctl),
                    .i_index (mte_pkg::IDX_W'(k)),
                    .i_ring  (w_cell[k+1]),
                    .i_up    (w_cell[k+1]),
                    .o_value (w_cell[k])
                );
            end
        end
    endgenerate

    mte_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scan_ctl),
        .i_entry (w_cell[0]),
        .o_res   (w_res)
    );

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_position    = r_o_position;
    assign o_overflow    = r_o_overflow;
    assign o_entry_count = r_o_count;
    assign o_min_value   = r_o_min;
    assign o_max_value   = r_o_max;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= mte_pkg::CNT_W'(mte_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_step == '0))
        else $error("accepted beat did not start a scan");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside finalize");

    a_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_overflow && r_o_found))
        else $error("overflow and found together");

    a_empty_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_count == '0)) |->
            (r_o_min == mte_pkg::WORD_MAX) && (r_o_max == mte_pkg::WORD_MIN))
        else $error("empty table reports bounds");

endmodule
